/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the Adam update engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check of a plain property, off while reset is high.
`define APU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked implication, off while reset is high.
`define APU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/apu_pkg.sv */
// Types and constants of the Adam update engine.
package apu_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_FIRST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_SECOND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_LIMIT    = 3'd5;

  localparam logic [31:0] LR_RESET    = 32'd66;
  localparam logic [15:0] B1_RESET    = 16'd58982;
  localparam logic [15:0] B2_RESET    = 16'd65470;
  localparam logic [15:0] EPS_RESET   = 16'd1;
  localparam logic [31:0] TOL_RESET   = 32'd66;
  localparam logic [15:0] LIMIT_RESET = 16'd1000;

  // Bias-correction quotients, step quotient and its cap.
  localparam int QUO_W   = 64;
  localparam int MH_W    = 48;
  localparam int STEP_QW = 41;
  localparam logic [STEP_QW-1:0] STEP_CAP = 41'h100_0000_0000;

  // One request as it leaves the run control.
  typedef struct packed {
    logic              valid;
    logic              active;
    logic              first;
    logic [7:0]        index;
    logic signed [31:0] gradient;
    logic signed [31:0] value;
    logic [31:0]       gmag;
    logic [31:0]       p1;
    logic [31:0]       p2;
    logic              pass_end;
    logic              converged;
    logic              run_done;
  } head_t;

  // What a request carries through the arithmetic tail.
  typedef struct packed {
    logic              valid;
    logic              active;
    logic              neg;
    logic [7:0]        index;
    logic signed [31:0] value;
    logic              pass_end;
    logic              converged;
    logic              run_done;
  } tail_t;

  // Special cases of the step division.
  typedef struct packed {
    logic cap;
    logic zero;
  } step_flag_t;

endpackage

/* rtl/adam_parameter_update.sv */
// Adam parameter update engine: run control, moment store and update pipeline.
//
//   Channel | Handshake            | Carries
//   --------+----------------------+-------------------------------------------------
//   cfg     | cfg_we               | cfg_index, cfg_data (register write, no read)
//   in      | in_valid / in_stall  | param_index, gradient, value, last_of_pass,
//           |                      | start_run
//   out     | out_valid / out_stall| out_index, new_value, pass_end, converged, run_done
//
// One request enters per cycle while in_stall is low. Latency from acceptance to
// out_valid is set by the bit-serial divider pipelines for bias correction and
// step and by the digit-by-digit root pipeline. After reset the moment memory is
// cleared, one entry a cycle; in_stall stays high during that pass while
// configuration writes are taken. The whole pipeline advances together and
// holds while a result waits on out_stall.
`include "assert_macros.svh"

module adam_parameter_update import apu_pkg::*; #(
  parameter int PARAM_COUNT   = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            param_index,
  input  logic signed [31:0]    gradient,
  input  logic signed [31:0]    value,
  input  logic                  last_of_pass,
  input  logic                  start_run,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_index,
  output logic signed [31:0]    new_value,
  output logic                  pass_end,
  output logic                  converged,
  output logic                  run_done
);

  localparam int AW   = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam int XW   = QUO_W + FRACTION_BITS;
  localparam int RW   = (XW + 1) / 2;
  localparam int DENW = RW + 1;
  localparam int SNW  = DENW + STEP_QW;
  localparam int LAT  = QUO_W + RW + STEP_QW + 4;

  // Root pipeline stage contents.
  typedef struct packed {
    logic [RW+1:0]   rem;
    logic [RW-1:0]   root;
    logic [2*RW-1:0] x;
  } sq_t;

  // Entry of an index in the store: index modulo PARAM_COUNT.
  function automatic logic [AW-1:0] entry_of(input logic [7:0] idx);
    logic [31:0] r;
    r = 32'(idx);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (32'(PARAM_COUNT) << k)) begin
        r = r - (32'(PARAM_COUNT) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  function automatic sq_t sq_step(input sq_t s);
    sq_t         o;
    logic [RW+1:0] rem2;
    logic [RW+1:0] trial;
    rem2  = {s.rem[RW-1:0], s.x[2*RW-1 -: 2]};
    trial = {s.root, 2'b01};
    if (rem2 >= trial) begin
      o.rem  = rem2 - trial;
      o.root = {s.root[RW-2:0], 1'b1};
    end else begin
      o.rem  = rem2;
      o.root = {s.root[RW-2:0], 1'b0};
    end
    o.x = {s.x[2*RW-3:0], 2'b00};
    return o;
  endfunction

  // Configuration registers.
  logic [31:0] learning_rate;
  logic [15:0] beta_first;
  logic [15:0] beta_second;
  logic [15:0] epsilon;
  logic [31:0] tolerance;
  logic [15:0] pass_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LR_RESET;
      beta_first    <= B1_RESET;
      beta_second   <= B2_RESET;
      epsilon       <= EPS_RESET;
      tolerance     <= TOL_RESET;
      pass_limit    <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEARNING_RATE: learning_rate <= cfg_data;
        REG_BETA_FIRST:    beta_first    <= cfg_data[15:0];
        REG_BETA_SECOND:   beta_second   <= cfg_data[15:0];
        REG_EPSILON:       epsilon       <= cfg_data[15:0];
        REG_TOLERANCE:     tolerance     <= cfg_data;
        REG_PASS_LIMIT:    pass_limit    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one; it holds only while a result waits.
  logic adv;
  logic accept;
  logic clr_active;
  logic [AW-1:0] clr_addr;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv || clr_active;
  assign accept   = in_valid && !in_stall;

  // Run control. Every accepted request sees the state that all earlier
  // requests left, so this part is evaluated in the acceptance cycle.
  logic        run_active;
  logic [15:0] pass_count;
  logic [31:0] largest;
  logic [31:0] p1;
  logic [31:0] p2;

  logic        act;
  logic [15:0] pc_cur;
  logic [15:0] pc_inc;
  logic [31:0] lg_cur;
  logic [31:0] lg_new;
  logic [31:0] p1_cur;
  logic [31:0] p2_cur;
  logic [47:0] p1_prod;
  logic [47:0] p2_prod;
  logic [31:0] gmag_in;
  logic        conv_in;
  logic        done_in;
  head_t       head_next;

  always_comb begin
    act     = start_run || run_active;
    pc_cur  = start_run ? 16'd0 : pass_count;
    lg_cur  = start_run ? 32'd0 : largest;
    p1_cur  = start_run ? {beta_first, 16'd0} : p1;
    p2_cur  = start_run ? {beta_second, 16'd0} : p2;
    gmag_in = gradient[31] ? (~$unsigned(gradient) + 32'd1) : $unsigned(gradient);
    lg_new  = (gmag_in > lg_cur) ? gmag_in : lg_cur;
    pc_inc  = (pc_cur != 16'hFFFF) ? pc_cur + 16'd1 : pc_cur;
    conv_in = act && last_of_pass && (lg_new < tolerance);
    done_in = act && last_of_pass && (conv_in || (pc_inc >= pass_limit));
    p1_prod = p1_cur * beta_first;
    p2_prod = p2_cur * beta_second;

    head_next.valid     = accept;
    head_next.active    = act;
    head_next.first     = (pc_cur == 16'd0);
    head_next.index     = param_index;
    head_next.gradient  = gradient;
    head_next.value     = value;
    head_next.gmag      = gmag_in;
    head_next.p1        = p1_cur;
    head_next.p2        = p2_cur;
    head_next.pass_end  = act && last_of_pass;
    head_next.converged = conv_in;
    head_next.run_done  = done_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      pass_count <= 16'd0;
      largest    <= 32'd0;
      p1         <= 32'd0;
      p2         <= 32'd0;
    end else if (accept && act) begin
      if (last_of_pass) begin
        pass_count <= pc_inc;
        run_active <= !done_in;
        if (done_in) begin
          largest <= lg_new;
          p1      <= p1_cur;
          p2      <= p2_cur;
        end else begin
          largest <= 32'd0;
          p1      <= p1_prod[47:16];
          p2      <= p2_prod[47:16];
        end
      end else begin
        run_active <= 1'b1;
        pass_count <= pc_cur;
        largest    <= lg_new;
        p1         <= p1_cur;
        p2         <= p2_cur;
      end
    end
  end

  // Clearing pass over the moment memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == AW'(PARAM_COUNT - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Stage A: accepted request, gradient squared.
  head_t         ha;
  logic [AW-1:0] ea;
  logic [63:0]   gsq;
  logic [63:0]   gsq_shift;
  logic [47:0]   s_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      ha.valid <= 1'b0;
    end else if (adv) begin
      ha <= head_next;
      ea <= entry_of(param_index);
    end
  end

  always_comb begin
    gsq       = ha.gmag * ha.gmag;
    gsq_shift = gsq >> FRACTION_BITS;
    s_a       = (gsq_shift[63:48] != 16'd0) ? 48'hFFFF_FFFF_FFFF : gsq_shift[47:0];
  end

  // Stage B: moment read, forwarding, moment update and write-back.
  head_t         hb;
  logic [AW-1:0] eb;
  logic [47:0]   s_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      hb.valid <= 1'b0;
    end else if (adv) begin
      hb  <= ha;
      eb  <= ea;
      s_b <= s_a;
    end
  end

  logic [AW-1:0]      ram_raddr;
  logic [79:0]        ram_rdata;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [79:0]        ram_wdata;
  logic               we_item;
  logic               fwd_valid;
  logic [AW-1:0]      fwd_addr;
  logic signed [31:0] fwd_m;
  logic [47:0]        fwd_v;
  logic               fwd_hit;
  logic signed [31:0] m_old;
  logic [47:0]        v_old;
  logic [16:0]        omb1;
  logic [16:0]        omb2;
  logic signed [50:0] m_sum;
  logic signed [31:0] m_new;
  logic [65:0]        v_sum;
  logic [47:0]        v_new;

  // Re-reading the held entry while stalled keeps the read data consistent.
  assign ram_raddr = adv ? ea : eb;

  always_comb begin
    fwd_hit = fwd_valid && (fwd_addr == eb);
    m_old   = hb.first ? 32'sd0 : (fwd_hit ? fwd_m : $signed(ram_rdata[79:48]));
    v_old   = hb.first ? 48'd0 : (fwd_hit ? fwd_v : ram_rdata[47:0]);
    omb1    = 17'h10000 - {1'b0, beta_first};
    omb2    = 17'h10000 - {1'b0, beta_second};
    m_sum   = $signed({1'b0, beta_first}) * m_old + $signed({1'b0, omb1}) * hb.gradient;
    m_new   = m_sum[47:16];
    v_sum   = beta_second * v_old + omb2 * s_b;
    v_new   = v_sum[63:16];
    we_item = adv && hb.valid && hb.active;
    ram_we    = clr_active || we_item;
    ram_waddr = clr_active ? clr_addr : eb;
    ram_wdata = clr_active ? 80'd0 : {m_new, v_new};
  end

  // The write of the request just ahead is not yet visible in the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (we_item) begin
      fwd_valid <= 1'b1;
      fwd_addr  <= eb;
      fwd_m     <= m_new;
      fwd_v     <= v_new;
    end
  end

  apu_ram #(
    .WIDTH (80),
    .DEPTH (PARAM_COUNT)
  ) u_moment_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stage C: new moments and bias-correction divisors.
  tail_t       tc;
  logic [31:0] c_mmag;
  logic [47:0] c_v;
  logic [32:0] c_d1;
  logic [32:0] c_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      tc.valid <= 1'b0;
    end else if (adv) begin
      tc.valid     <= hb.valid;
      tc.active    <= hb.active;
      tc.neg       <= m_new[31];
      tc.index     <= hb.index;
      tc.value     <= hb.value;
      tc.pass_end  <= hb.pass_end;
      tc.converged <= hb.converged;
      tc.run_done  <= hb.run_done;
      c_mmag       <= m_new[31] ? (~$unsigned(m_new) + 32'd1) : $unsigned(m_new);
      c_v          <= v_new;
      c_d1         <= 33'h1_0000_0000 - {1'b0, hb.p1};
      c_d2         <= 33'h1_0000_0000 - {1'b0, hb.p2};
    end
  end

  // Bias correction: both quotients run side by side.
  logic [QUO_W-1:0] qm;
  logic [QUO_W-1:0] qv;

  apu_div_pipe #(
    .DW (33),
    .QW (QUO_W)
  ) u_div_m (
    .clk (clk),
    .en  (adv),
    .num ({33'd0, c_mmag, 32'd0}),
    .den (c_d1),
    .quo (qm)
  );

  apu_div_pipe #(
    .DW (33),
    .QW (QUO_W)
  ) u_div_v (
    .clk (clk),
    .en  (adv),
    .num ({17'd0, c_v, 32'd0}),
    .den (c_d2),
    .quo (qv)
  );

  // Square root of the corrected second moment, two radicand bits a stage.
  sq_t              sq [RW];
  logic [MH_W-1:0]  mh_dly [RW];
  sq_t              sq_in;

  always_comb begin
    sq_in.rem  = '0;
    sq_in.root = '0;
    sq_in.x    = (2*RW)'({qv, {FRACTION_BITS{1'b0}}});
  end

  for (genvar i = 0; i < RW; i++) begin : g_root
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          sq[i]     <= sq_step(sq_in);
          mh_dly[i] <= qm[MH_W-1:0];
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) begin
          sq[i]     <= sq_step(sq[i-1]);
          mh_dly[i] <= mh_dly[i-1];
        end
      end
    end
  end

  // Denominator and the two halves of learning_rate * corrected first moment.
  logic [DENW-1:0] f_den;
  logic [55:0]     f_pp_lo;
  logic [55:0]     f_pp_hi;
  logic [79:0]     g_num;
  logic [DENW-1:0] g_den;
  logic [SNW+79:0] g_num_ext;
  logic            h_cap_next;
  step_flag_t      h_flag;
  logic [SNW-1:0]  h_num;
  logic [DENW-1:0] h_den;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_den   <= DENW'(sq[RW-1].root) + DENW'(epsilon);
      f_pp_lo <= learning_rate * mh_dly[RW-1][23:0];
      f_pp_hi <= learning_rate * mh_dly[RW-1][47:24];
      g_num   <= 80'(f_pp_lo) + {f_pp_hi, 24'd0};
      g_den   <= f_den;
    end
  end

  // A quotient of 2^41 or more is capped before the divider sees it.
  always_comb begin
    g_num_ext  = {{SNW{1'b0}}, g_num};
    h_cap_next = ({41'd0, g_num[79:41]} >= 80'(g_den));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_flag.zero <= (g_den == '0);
      h_flag.cap  <= (g_den != '0) && h_cap_next;
      h_num       <= ((g_den == '0) || h_cap_next) ? '0 : g_num_ext[SNW-1:0];
      h_den       <= (g_den == '0) ? DENW'(1) : g_den;
    end
  end

  logic [STEP_QW-1:0] q_step;
  step_flag_t         sf_dly [STEP_QW];

  apu_div_pipe #(
    .DW (DENW),
    .QW (STEP_QW)
  ) u_div_step (
    .clk (clk),
    .en  (adv),
    .num (h_num),
    .den (h_den),
    .quo (q_step)
  );

  for (genvar i = 0; i < STEP_QW; i++) begin : g_flag
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          sf_dly[i] <= h_flag;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) begin
          sf_dly[i] <= sf_dly[i-1];
        end
      end
    end
  end

  logic [STEP_QW-1:0] j_step;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sf_dly[STEP_QW-1].cap) begin
        j_step <= STEP_CAP;
      end else if (sf_dly[STEP_QW-1].zero) begin
        j_step <= '0;
      end else begin
        j_step <= (q_step > STEP_CAP) ? STEP_CAP : q_step;
      end
    end
  end

  // Request fields ride alongside the arithmetic.
  tail_t side_dly [LAT];

  for (genvar i = 0; i < LAT; i++) begin : g_side
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          side_dly[i].valid <= 1'b0;
        end else if (adv) begin
          side_dly[i] <= tc;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          side_dly[i].valid <= 1'b0;
        end else if (adv) begin
          side_dly[i] <= side_dly[i-1];
        end
      end
    end
  end

  // Output register: apply the step with saturation, or pass the value of an inactive request through.
  tail_t              tj;
  logic signed [42:0] val_ext;
  logic signed [42:0] step_ext;
  logic signed [42:0] res;
  logic signed [31:0] res_sat;

  always_comb begin
    tj       = side_dly[LAT-1];
    val_ext  = $signed({{11{tj.value[31]}}, tj.value});
    step_ext = $signed({2'b00, j_step});
    res      = tj.neg ? (val_ext + step_ext) : (val_ext - step_ext);
    if (res > 43'sd2147483647) begin
      res_sat = 32'sh7FFF_FFFF;
    end else if (res < -43'sd2147483648) begin
      res_sat = 32'sh8000_0000;
    end else begin
      res_sat = res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tj.valid;
      out_index <= tj.index;
      new_value <= tj.active ? res_sat : tj.value;
      pass_end  <= tj.pass_end;
      converged <= tj.converged;
      run_done  <= tj.run_done;
    end
  end

  // A run only ends on an accepted request that closes a pass.
  `APU_ASSERT_IMP(a_run_end, $fell(run_active) && !$past(rst), $past(accept && last_of_pass), "run ended without a closing request")
  // The pass count moves only with an accepted request.
  `APU_ASSERT_IMP(a_count_hold, !accept, ##1 $stable(pass_count), "pass count changed without a request")
  // No moment write-back may collide with the clearing pass.
  `APU_ASSERT(a_no_write_clear, !(clr_active && we_item), "moment write during clearing pass")

endmodule

/* rtl/apu_ram.sv */
// Generic single-port-write, registered-read RAM.
module apu_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/apu_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage.
module apu_div_pipe #(
  parameter int DW = 33,
  parameter int QW = 64
) (
  input  logic           clk,
  input  logic           en,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]  den,
  output logic [QW-1:0]  quo
);

  localparam int WW = DW + QW;

  // The top DW bits of num must be below den.
  logic [WW-1:0] w [QW];
  logic [DW-1:0] d [QW];

  function automatic logic [WW-1:0] div_step(input logic [WW-1:0] w_in,
                                             input logic [DW-1:0] d_in);
    logic [WW:0] sh;
    logic [DW:0] top;
    sh  = {w_in, 1'b0};
    top = sh[WW:QW];
    if (top >= {1'b0, d_in}) begin
      top   = top - {1'b0, d_in};
      sh[0] = 1'b1;
    end
    return {top[DW-1:0], sh[QW-1:0]};
  endfunction

  for (genvar i = 0; i < QW; i++) begin : g_stage
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          w[i] <= div_step(num, den);
          d[i] <= den;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          w[i] <= div_step(w[i-1], d[i-1]);
          d[i] <= d[i-1];
        end
      end
    end
  end

  assign quo = w[QW-1][QW-1:0];

endmodule

/* test/adam_parameter_update_checker.sv */
// Checker for the Adam update engine: predicts each update and compares the results.
module adam_parameter_update_checker import apu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            param_index,
  input  logic signed [31:0]    gradient,
  input  logic signed [31:0]    value,
  input  logic                  last_of_pass,
  input  logic                  start_run,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [7:0]            out_index,
  input  logic signed [31:0]    new_value,
  input  logic                  pass_end,
  input  logic                  converged,
  input  logic                  run_done,
  output int                    failures,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PCOUNT = 256;

  typedef struct {
    logic [7:0]         index;
    logic signed [31:0] value;
    logic               pass_end;
    logic               converged;
    logic               run_done;
  } update_t;

  update_t updates_due[$];

  longint lr, b1, b2, eps, tol, limit;
  longint m_store [PCOUNT];
  logic [63:0] v_store [PCOUNT];
  longint p1, p2, passes, peak_grad;
  bit active;

  assign pending = updates_due.size();

  function automatic logic [127:0] isqrt(input logic [127:0] x);
    logic [127:0] root, rem, trial;
    root = 0;
    rem = 0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 2) | x[2*k +: 2];
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic update_t adam_step(input logic [7:0] idx, input longint g,
                                        input longint val, input bit last, input bit start);
    update_t r;
    longint m_old, m_new, gmag, res, t;
    logic [127:0] v_old, s, v_new, m_mag, m_hat, v_hat, den, step, d1, d2;
    bit first;
    r.index = idx;
    r.pass_end = 0;
    r.converged = 0;
    r.run_done = 0;
    res = val;
    if (start) begin
      active = 1;
      passes = 0;
      peak_grad = 0;
      p1 = b1 << 16;
      p2 = b2 << 16;
    end
    if (active) begin
      first = (passes == 0);
      m_old = first ? 0 : m_store[idx];
      v_old = first ? 0 : v_store[idx];
      gmag = (g < 0) ? -g : g;
      t = b1 * m_old + (65536 - b1) * g;
      m_new = t >>> 16;
      s = 128'(gmag * gmag) >> 16;
      v_new = (128'(b2) * v_old + 128'(65536 - b2) * s) >> 16;
      m_store[idx] = m_new;
      v_store[idx] = v_new[63:0];
      d1 = 128'(64'h1_0000_0000 - p1);
      d2 = 128'(64'h1_0000_0000 - p2);
      m_mag = 128'((m_new < 0) ? -m_new : m_new);
      m_hat = (m_mag << 32) / d1;
      v_hat = (v_new << 32) / d2;
      den = isqrt(v_hat << 16) + 128'(eps);
      if (den == 0) step = 0;
      else step = (m_hat * 128'(lr)) / den;
      if (step > (128'd1 << 40)) step = 128'd1 << 40;
      res = (m_new < 0) ? val + longint'(step) : val - longint'(step);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      if (gmag > peak_grad) peak_grad = gmag;
      if (last) begin
        r.pass_end = 1;
        r.converged = (peak_grad < tol);
        if (passes < 65535) passes++;
        r.run_done = r.converged || (passes >= limit);
        if (r.run_done) begin
          active = 0;
        end else begin
          p1 = (p1 * b1) >> 16;
          p2 = (p2 * b2) >> 16;
          peak_grad = 0;
        end
      end
    end
    r.value = res[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    update_t want;
    if (rst) begin
      lr = LR_RESET;
      b1 = B1_RESET;
      b2 = B2_RESET;
      eps = EPS_RESET;
      tol = TOL_RESET;
      limit = LIMIT_RESET;
      for (int i = 0; i < PCOUNT; i++) begin
        m_store[i] = 0;
        v_store[i] = 0;
      end
      p1 = 0;
      p2 = 0;
      passes = 0;
      peak_grad = 0;
      active = 0;
      failures = 0;
      updates_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEARNING_RATE: lr = cfg_data;
          REG_BETA_FIRST:    b1 = cfg_data[15:0];
          REG_BETA_SECOND:   b2 = cfg_data[15:0];
          REG_EPSILON:       eps = cfg_data[15:0];
          REG_TOLERANCE:     tol = cfg_data;
          REG_PASS_LIMIT:    limit = cfg_data[15:0];
          default: ;
        endcase
      end
      // The output side is checked before the new request is predicted, so an
      // update is never compared against its own prediction in the same cycle.
      if (out_valid && !out_stall) begin
        if (updates_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected update: index %0d value %0d", out_index, new_value);
        end else begin
          want = updates_due.pop_front();
          if (want.index !== out_index || want.value !== new_value ||
              want.pass_end !== pass_end || want.converged !== converged ||
              want.run_done !== run_done) begin
            failures++;
            if (failures <= 10)
              $display("update differs: expected idx %0d val %0d end %b conv %b done %b, got idx %0d val %0d end %b conv %b done %b",
                       want.index, want.value, want.pass_end, want.converged,
                       want.run_done, out_index, new_value, pass_end, converged,
                       run_done);
          end
        end
      end
      if (in_valid && !in_stall)
        updates_due.push_back(adam_step(param_index, longint'(gradient),
                                        longint'(value), last_of_pass, start_run));
    end
  end
endmodule

/* test/adam_parameter_update_test.sv */
// Top of the Adam update engine testbench: stimulus, flow control and verdict.
module adam_parameter_update_test;
  import apu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            param_index;
  logic signed [31:0]    gradient;
  logic signed [31:0]    value;
  logic                  last_of_pass;
  logic                  start_run;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_index;
  logic signed [31:0]    new_value;
  logic                  pass_end;
  logic                  converged;
  logic                  run_done;
  int                    failures;
  int                    pending;

  // Percentages of cycles in which each side idles, changed per phase.
  int  tx_idle_pct;
  int  rx_idle_pct;
  // Set once to start the long receiver hold-off.
  bit  hold_go;
  logic long_hold;
  int  sent;

  adam_parameter_update uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .param_index(param_index),
    .gradient(gradient), .value(value), .last_of_pass(last_of_pass),
    .start_run(start_run), .out_valid(out_valid), .out_stall(out_stall),
    .out_index(out_index), .new_value(new_value), .pass_end(pass_end),
    .converged(converged), .run_done(run_done)
  );

  adam_parameter_update_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .param_index(param_index),
    .gradient(gradient), .value(value), .last_of_pass(last_of_pass),
    .start_run(start_run), .out_valid(out_valid), .out_stall(out_stall),
    .out_index(out_index), .new_value(new_value), .pass_end(pass_end),
    .converged(converged), .run_done(run_done), .failures(failures),
    .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, and for one long stretch when asked, so that
  // the pipeline fills up and pushes back on the sender.
  always @(posedge clk) begin
    out_stall <= long_hold || ($urandom_range(0, 99) < rx_idle_pct);
  end

  initial begin
    long_hold = 0;
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1;
    repeat (700) @(posedge clk);
    long_hold <= 0;
  end

  // Generous overall limit; a correct run needs far less.
  initial begin
    #5ms;
    $display("adam_parameter_update: mismatch");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Offers one request, waits for the edge where it is taken, then idles
  // the sender for a random number of cycles, each with the set chance.
  task automatic send(input logic [7:0] idx, input logic [31:0] g, input logic [31:0] v,
                      input bit last, input bit start);
    in_valid <= 1;
    param_index <= idx;
    gradient <= g;
    value <= v;
    last_of_pass <= last;
    start_run <= start;
    do @(posedge clk); while (in_stall);
    sent++;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Every request produces a result, so this only lets the pipeline settle.
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_gradient;
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 8 * 65536) - 4 * 65536;
    endcase
  endfunction

  function automatic logic [31:0] pick_value;
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ff00 + $urandom_range(0, 255);
      1: return 32'h8000_0000 + $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // One run of well-formed passes over a small random set of indexes, followed by
  // up to two items that close no pass and start no run.
  task automatic run_passes;
    logic [7:0] idx [8];
    int n, npass;
    n = $urandom_range(1, 8);
    npass = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) idx[i] = $urandom_range(0, 255);
    for (int p = 0; p < npass; p++)
      for (int i = 0; i < n; i++)
        send(idx[i], pick_gradient(), pick_value(), i == n - 1, p == 0 && i == 0);
    repeat ($urandom_range(0, 2))
      send($urandom_range(0, 255), pick_gradient(), pick_value(), 0, 0);
  endtask

  task automatic noise;
    send($urandom_range(0, 255), pick_gradient(), pick_value(),
         $urandom_range(0, 1), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    logic [31:0] cfg_lr, cfg_tol;
    logic [15:0] cfg_b1, cfg_b2, cfg_eps, cfg_lim;
    int target;
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_LEARNING_RATE;
    cfg_data = 0;
    in_valid = 0;
    param_index = 0;
    gradient = 0;
    value = 0;
    last_of_pass = 0;
    start_run = 0;
    tx_idle_pct = 25;
    rx_idle_pct = 74;
    hold_go = 0;
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part at reset settings: idle pass-through before any run, field
    // extremes, the most negative gradient, the top index and run end.
    send(8'd0, 32'h0001_0000, 32'h1234_5678, 0, 0);
    send(8'd255, 32'h8000_0000, 32'h7fff_ffff, 0, 1);
    send(8'd0, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    send(8'd1, 32'h0000_0000, 32'h0000_0000, 0, 0);
    send(8'd2, 32'hffff_ffff, 32'hffff_ffff, 1, 0);
    send(8'd255, 32'h0000_0001, 32'h7fff_ffff, 0, 0);
    send(8'd0, 32'h0000_0040, 32'h8000_0000, 0, 0);
    send(8'd1, 32'h0000_0000, 32'h0001_0000, 0, 0);
    send(8'd2, 32'h0000_0010, 32'hfffe_0000, 1, 0);
    send(8'd7, 32'h0001_0000, 32'h0000_1000, 1, 0);
    send(8'd3, 32'h0000_0001, 32'h0000_0001, 1, 1);
    send(8'd3, 32'h0000_0002, 32'h0000_0002, 1, 0);
    send(8'd9, 32'h7fff_ffff, 32'h5555_5555, 0, 0);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          cfg_lr = 32'h0001_0000; cfg_b1 = 16'd58982; cfg_b2 = 16'd65470;
          cfg_eps = 16'd1; cfg_tol = 32'h0002_0000; cfg_lim = 16'd4;
        end
        1: begin
          // Zero betas, zero epsilon and a pass limit of zero.
          cfg_lr = 32'hffff_ffff; cfg_b1 = 16'd0; cfg_b2 = 16'd0;
          cfg_eps = 16'd0; cfg_tol = 32'd0; cfg_lim = 16'd0;
        end
        2: begin
          cfg_lr = 32'd0; cfg_b1 = 16'hffff; cfg_b2 = 16'hffff;
          cfg_eps = 16'hffff; cfg_tol = 32'hffff_ffff; cfg_lim = 16'hffff;
        end
        4: begin
          cfg_lr = LR_RESET; cfg_b1 = B1_RESET; cfg_b2 = B2_RESET;
          cfg_eps = EPS_RESET; cfg_tol = 32'h0001_0000; cfg_lim = 16'd3;
        end
        default: begin
          cfg_lr = $urandom; cfg_b1 = $urandom; cfg_b2 = $urandom;
          cfg_eps = $urandom_range(1, 65535); cfg_tol = $urandom_range(0, 32'h0004_0000);
          cfg_lim = $urandom_range(1, 5);
        end
      endcase
      write_reg(REG_LEARNING_RATE, cfg_lr);
      write_reg(REG_BETA_FIRST, {16'd0, cfg_b1});
      write_reg(REG_BETA_SECOND, {16'd0, cfg_b2});
      write_reg(REG_EPSILON, {16'd0, cfg_eps});
      write_reg(REG_TOLERANCE, cfg_tol);
      write_reg(REG_PASS_LIMIT, {16'd0, cfg_lim});

      // Idling swaps sides after two phases and stops for the last two.
      tx_idle_pct = (phase < 2) ? 25 : (phase < 4) ? 74 : 0;
      rx_idle_pct = (phase < 2) ? 74 : (phase < 4) ? 25 : 0;

      target = sent + 190;
      while (sent < target) begin
        if ($urandom_range(0, 9) < 8) run_passes();
        else noise();
        // With nothing idling, the long hold-off fills the pipeline.
        if (phase == 4 && !hold_go && sent > target - 150) hold_go = 1;
        // In a window of phase 2 the sender waits for every outstanding result.
        if (phase == 2 && sent > target - 100 && sent < target - 80) begin
          in_valid <= 0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
    end

    drain();
    if (failures == 0 && pending == 0) begin
      $display("adam_parameter_update: match");
    end else begin
      $display("adam_parameter_update: mismatch");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl
rtl/apu_pkg.sv
rtl/apu_ram.sv
rtl/apu_div_pipe.sv
rtl/adam_parameter_update.sv
test/adam_parameter_update_checker.sv
test/adam_parameter_update_test.sv
